### rtl/pptdq_pkg.sv
`default_nettype none
package pptdq_pkg;
    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_OPEN  = 2'd2,
        OP_CLOSE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_POOL      = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_OPEN      = 3'd4
    } status_t;

    localparam int unsigned LIMIT_BITS  = 9;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 9'd100;
    localparam int unsigned OP_BITS     = 2;
    localparam int unsigned PORT_BITS   = 4;
    localparam int unsigned STATUS_BITS = 3;
endpackage
`default_nettype wire

### rtl/per_port_tail_drop_queue_manager_top.sv
`default_nettype none
// per-port tail-drop queue manager: fifo queues of packet handles for up to PORT_COUNT
// output ports, linked through a shared pool of POOL_ENTRIES buffer entries. an item
// (op, port, pdu_handle) gives exactly one result item (status, handle_out, handle_valid,
// depth_after). the link and handle memories (synchronous, registered read) are read
// at the edge that accepts the item, the next cycle updates the pointers and writes back,
// and the result item is offered the cycle after that. the input is held off while an
// item is being worked on or its result waits, so the next item is accepted the cycle
// after the result is taken, and no new item is taken before the last one's result is.
// after reset the link memory is initialized by a clearing pass over all POOL_ENTRIES
// entries, during which no item is accepted; configuration writes are taken at all times.
module per_port_tail_drop_queue_manager_top
    import pptdq_pkg::*;
#(
    parameter int unsigned PORT_COUNT   = 16,
    parameter int unsigned POOL_ENTRIES = 256,
    parameter int unsigned HANDLE_BITS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config: queue_limit [8:0]
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [LIMIT_BITS-1:0] cfg_data,
    // s_axis_tdata: op [1:0], port [5:2], pdu_handle [21:6], zero fill to 24 bits
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,
    // m_axis_tdata: status [2:0], handle_out [18:3], handle_valid [19],
    // depth_after [28:20], zero fill to 32 bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata
);
    localparam int unsigned PB = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int unsigned AB = $clog2(POOL_ENTRIES);
    localparam int unsigned CB = $clog2(POOL_ENTRIES + 1);
    localparam int unsigned HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    typedef enum logic [1:0] { S_INIT, S_IDLE, S_READ, S_OUT } state_t;

    state_t state_reg;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [AB-1:0] init_idx_reg;

    // per-port state in flip-flops
    logic [PORT_COUNT-1:0] active_reg;
    logic [LIMIT_BITS-1:0] depth_reg [PORT_COUNT];
    logic [AB-1:0] head_reg [PORT_COUNT];
    logic [AB-1:0] tail_reg [PORT_COUNT];
    logic [AB-1:0] free_head_reg;
    logic [CB-1:0] free_count_reg;

    // memories
    logic [AB-1:0] link_mem [POOL_ENTRIES];
    logic [HB-1:0] hdl_mem [POOL_ENTRIES];
    logic [AB-1:0] link_rd_reg;
    logic [HB-1:0] hdl_rd_reg;

    // captured item
    op_t op_reg;
    logic [PORT_BITS-1:0] port_reg;
    logic [15:0] pdu_reg;

    logic [STATUS_BITS-1:0] st_reg;
    logic [15:0] hout_reg;
    logic hval_reg;
    logic [LIMIT_BITS-1:0] dep_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {3'd0, dep_reg, hval_reg, hout_reg, st_reg};

    logic in_range;
    logic [PB-1:0] pi;
    assign in_range = ({28'd0, port_reg} < 32'(PORT_COUNT));
    assign pi = PB'(port_reg);

    // read address: dequeue reads the head entry, enqueue the free head
    logic [AB-1:0] rd_addr;
    assign rd_addr = (op_t'(s_axis_tdata[1:0]) == OP_DEQ)
        ? head_reg[PB'(s_axis_tdata[5:2])] : free_head_reg;

    // memory writes
    logic wr_en;
    logic [AB-1:0] wr_addr, wr_data;
    logic hw_en;

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        hw_en = 1'b0;
        if (state_reg == S_INIT)
        begin
            wr_en = 1'b1;
            wr_addr = init_idx_reg;
            // last entry wraps to entry zero
            if (init_idx_reg == AB'(POOL_ENTRIES - 1))
                wr_data = '0;
            else
                wr_data = init_idx_reg + AB'(1);
        end
        else if (state_reg == S_READ && in_range && active_reg[pi])
        begin
            unique case (op_reg)
                OP_ENQ:
                begin
                    if (depth_reg[pi] < limit_reg && free_count_reg != '0)
                    begin
                        hw_en = 1'b1;
                        if (depth_reg[pi] != '0)
                        begin
                            wr_en = 1'b1;
                            wr_addr = tail_reg[pi];
                            wr_data = free_head_reg;
                        end
                    end
                end
                OP_DEQ:
                begin
                    if (depth_reg[pi] != '0)
                    begin
                        wr_en = 1'b1;
                        wr_addr = head_reg[pi];
                        wr_data = free_head_reg;
                    end
                end
                OP_CLOSE:
                begin
                    if (depth_reg[pi] != '0)
                    begin
                        wr_en = 1'b1;
                        wr_addr = tail_reg[pi];
                        wr_data = free_head_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        if (hw_en)
            hdl_mem[free_head_reg] <= pdu_reg[HB-1:0];
        link_rd_reg <= link_mem[rd_addr];
        hdl_rd_reg  <= hdl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            limit_reg <= LIMIT_RESET;
            init_idx_reg <= '0;
            active_reg <= '0;
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                depth_reg[i] <= '0;
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            free_head_reg <= '0;
            free_count_reg <= CB'(POOL_ENTRIES);
            op_reg <= OP_ENQ;
            port_reg <= '0;
            pdu_reg <= '0;
            st_reg <= ST_OK;
            hout_reg <= '0;
            hval_reg <= 1'b0;
            dep_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            unique case (state_reg)
                S_INIT:
                begin
                    init_idx_reg <= init_idx_reg + AB'(1);
                    if (init_idx_reg == AB'(POOL_ENTRIES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        op_reg <= op_t'(s_axis_tdata[1:0]);
                        port_reg <= s_axis_tdata[5:2];
                        pdu_reg <= s_axis_tdata[21:6];
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_OUT;
                    st_reg <= ST_OK;
                    hout_reg <= '0;
                    hval_reg <= 1'b0;
                    dep_reg <= '0;
                    if (!in_range)
                        st_reg <= ST_UNKNOWN;
                    else if (op_reg == OP_OPEN)
                    begin
                        if (active_reg[pi])
                        begin
                            st_reg <= ST_OPEN;
                            dep_reg <= depth_reg[pi];
                        end
                        else
                        begin
                            active_reg[pi] <= 1'b1;
                            depth_reg[pi] <= '0;
                        end
                    end
                    else if (!active_reg[pi])
                    begin
                        st_reg <= ST_UNKNOWN;
                        dep_reg <= depth_reg[pi];
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_ENQ:
                            begin
                                dep_reg <= depth_reg[pi];
                                if (depth_reg[pi] >= limit_reg)
                                    st_reg <= ST_FULL;
                                else if (free_count_reg == '0)
                                    st_reg <= ST_POOL;
                                else
                                begin
                                    free_head_reg <= link_rd_reg;
                                    free_count_reg <= free_count_reg - CB'(1);
                                    if (depth_reg[pi] == '0)
                                        head_reg[pi] <= free_head_reg;
                                    tail_reg[pi] <= free_head_reg;
                                    depth_reg[pi] <= depth_reg[pi] + 9'd1;
                                    dep_reg <= depth_reg[pi] + 9'd1;
                                end
                            end
                            OP_DEQ:
                            begin
                                dep_reg <= depth_reg[pi];
                                if (depth_reg[pi] != '0)
                                begin
                                    hout_reg <= 16'(hdl_rd_reg);
                                    hval_reg <= 1'b1;
                                    head_reg[pi] <= link_rd_reg;
                                    depth_reg[pi] <= depth_reg[pi] - 9'd1;
                                    dep_reg <= depth_reg[pi] - 9'd1;
                                    free_head_reg <= head_reg[pi];
                                    free_count_reg <= free_count_reg + CB'(1);
                                end
                            end
                            default:
                            begin
                                if (depth_reg[pi] != '0)
                                begin
                                    free_head_reg <= head_reg[pi];
                                    free_count_reg <= free_count_reg
                                        + CB'(depth_reg[pi]);
                                end
                                depth_reg[pi] <= '0;
                                active_reg[pi] <= 1'b0;
                            end
                        endcase
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_INIT;
            endcase
        end
    end

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CB'(POOL_ENTRIES))
        else $error("free count above pool size");
    a_valid_only_deq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[19]) |-> (op_reg == OP_DEQ))
        else $error("handle valid on non-dequeue");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted while result pending");
endmodule
`default_nettype wire

### verif/per_port_tail_drop_queue_manager_top_tb.sv
`timescale 1ns / 1ps
module per_port_tail_drop_queue_manager_top_tb;
    import pptdq_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 600;

    typedef struct {
        status_t     st;
        logic [15:0] handle;
        logic        hvalid;
        logic [8:0]  depth;
    } queue_result_t;

    typedef struct {
        op_t           op;
        logic [3:0]    port;
        logic [15:0]   handle;
        bit            typed;
        queue_result_t res;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [LIMIT_BITS-1:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [23:0] s_axis_tdata;   // op [1:0], port [5:2], pdu_handle [21:6], zero fill
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [31:0] m_axis_tdata;   // status [2:0], handle_out [18:3], handle_valid [19],
                                 // depth_after [28:20], zero fill

    per_port_tail_drop_queue_manager_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // predictor state: port table, link memory, free list
    logic [8:0]  lim;
    bit          active [16];
    logic [8:0]  qdepth [16];
    logic [7:0]  qhead [16];
    logic [7:0]  qtail [16];
    logic [7:0]  link [256];
    logic [15:0] stash [256];
    logic [7:0]  free_hd;
    logic [8:0]  free_cnt;

    queue_result_t pending_results [$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int drops_seen = 0;
    int pops_seen = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_req = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("mismatch at result %0d: %s expected %0h got %0h",
                 results_seen, what, exp_v, got_v);
        errors++;
    endtask

    // one queue operation against the predictor state
    task automatic apply_queue_op(input op_t op, input logic [3:0] p, input logic [15:0] h,
                                  output queue_result_t r);
        logic [7:0] e;
        r.st = ST_OK;
        r.handle = '0;
        r.hvalid = 1'b0;
        r.depth = '0;
        if (op == OP_OPEN)
        begin
            if (active[p])
                r.st = ST_OPEN;
            else
            begin
                active[p] = 1'b1;
                qdepth[p] = '0;
            end
            r.depth = qdepth[p];
        end
        else if (!active[p])
        begin
            r.st = ST_UNKNOWN;
            r.depth = qdepth[p];
        end
        else if (op == OP_ENQ)
        begin
            if (qdepth[p] >= lim)
                r.st = ST_FULL;
            else if (free_cnt == 0)
                r.st = ST_POOL;
            else
            begin
                e = free_hd;
                free_hd = link[e];
                free_cnt--;
                stash[e] = h;
                if (qdepth[p] == 0)
                    qhead[p] = e;
                else
                    link[qtail[p]] = e;
                qtail[p] = e;
                qdepth[p]++;
            end
            r.depth = qdepth[p];
        end
        else if (op == OP_DEQ)
        begin
            if (qdepth[p] != 0)
            begin
                e = qhead[p];
                r.handle = stash[e];
                r.hvalid = 1'b1;
                qhead[p] = link[e];
                qdepth[p]--;
                link[e] = free_hd;
                free_hd = e;
                free_cnt++;
            end
            r.depth = qdepth[p];
        end
        else
        begin
            // close splices the whole chain onto the free list
            if (qdepth[p] != 0)
            begin
                link[qtail[p]] = free_hd;
                free_hd = qhead[p];
                free_cnt += qdepth[p];
            end
            qdepth[p] = '0;
            active[p] = 1'b0;
        end
    endtask

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_item(input op_t op, input logic [3:0] p, input logic [15:0] h,
                             input bit typed, input queue_result_t typed_res);
        int gap;
        queue_result_t r;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, h, p, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_queue_op(op, p, h, r);
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(input logic [8:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        lim = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(input int n);
        op_t op;
        logic [3:0] p;
        int roll;
        queue_result_t none;
        none = '{ST_OK, 16'h0, 1'b0, 9'h0};
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 45)
                op = OP_ENQ;
            else if (roll < 80)
                op = OP_DEQ;
            else if (roll < 92)
                op = OP_OPEN;
            else
                op = OP_CLOSE;
            // mostly a few busy ports so queues grow, sometimes any port
            p = ($urandom_range(9) < 8) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
            if ($urandom_range(49) == 0)
                quiet = !quiet;
            send_item(op, p, 16'($urandom), 1'b0, none);
        end
        quiet = 0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 0;
            end
            stall = gap_len();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        queue_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result item %0h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[2:0] != exp_r.st)
                    report_mismatch("status", exp_r.st, m_axis_tdata[2:0]);
                if (m_axis_tdata[18:3] != exp_r.handle)
                    report_mismatch("handle_out", exp_r.handle, m_axis_tdata[18:3]);
                if (m_axis_tdata[19] != exp_r.hvalid)
                    report_mismatch("handle_valid", exp_r.hvalid, m_axis_tdata[19]);
                if (m_axis_tdata[28:20] != exp_r.depth)
                    report_mismatch("depth_after", exp_r.depth, m_axis_tdata[28:20]);
                if (exp_r.st == ST_FULL || exp_r.st == ST_POOL)
                    drops_seen++;
                if (exp_r.hvalid)
                    pops_seen++;
                results_seen++;
            end
        end
    end

    initial
    begin
        directed_row_t rows [$];
        queue_result_t none;
        int i;
        none = '{ST_OK, 16'h0, 1'b0, 9'h0};

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        lim = LIMIT_RESET;
        free_hd = '0;
        free_cnt = 9'd256;
        for (i = 0; i < 16; i++)
        begin
            active[i] = 1'b0;
            qdepth[i] = '0;
            qhead[i] = '0;
            qtail[i] = '0;
        end
        for (i = 0; i < 256; i++)
        begin
            link[i] = 8'(i + 1);
            stash[i] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: closed ports, open twice, handle extremes, close and reopen
        rows.push_back('{OP_ENQ,   4'd0,  16'h1234, 1, '{ST_UNKNOWN, 16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_DEQ,   4'd0,  16'h0,    1, '{ST_UNKNOWN, 16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_CLOSE, 4'd15, 16'h0,    1, '{ST_UNKNOWN, 16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_OPEN,  4'd0,  16'h0,    1, '{ST_OK,      16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_OPEN,  4'd0,  16'h0,    1, '{ST_OPEN,    16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_DEQ,   4'd0,  16'h0,    1, '{ST_OK,      16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_ENQ,   4'd0,  16'h0000, 1, '{ST_OK,      16'h0, 1'b0, 9'd1}});
        rows.push_back('{OP_ENQ,   4'd0,  16'hffff, 1, '{ST_OK,      16'h0, 1'b0, 9'd2}});
        rows.push_back('{OP_OPEN,  4'd0,  16'h0,    1, '{ST_OPEN,    16'h0, 1'b0, 9'd2}});
        rows.push_back('{OP_DEQ,   4'd0,  16'h0,    1, '{ST_OK,      16'h0000, 1'b1, 9'd1}});
        rows.push_back('{OP_DEQ,   4'd0,  16'h0,    1, '{ST_OK,      16'hffff, 1'b1, 9'd0}});
        rows.push_back('{OP_OPEN,  4'd15, 16'h0,    1, '{ST_OK,      16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_ENQ,   4'd15, 16'ha5a5, 0, none});
        rows.push_back('{OP_ENQ,   4'd15, 16'h5a5a, 0, none});
        rows.push_back('{OP_ENQ,   4'd0,  16'h8001, 0, none});
        rows.push_back('{OP_CLOSE, 4'd15, 16'h0,    1, '{ST_OK,      16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_ENQ,   4'd15, 16'h7777, 1, '{ST_UNKNOWN, 16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_OPEN,  4'd15, 16'h0,    1, '{ST_OK,      16'h0, 1'b0, 9'd0}});
        rows.push_back('{OP_ENQ,   4'd15, 16'h0f0f, 0, none});
        rows.push_back('{OP_DEQ,   4'd15, 16'h0,    0, none});
        rows.push_back('{OP_DEQ,   4'd0,  16'h0,    0, none});
        rows.push_back('{OP_CLOSE, 4'd0,  16'h0,    0, none});
        foreach (rows[k])
            send_item(rows[k].op, rows[k].port, rows[k].handle, rows[k].typed, rows[k].res);
        wait_drained();

        // limit of zero drops every enqueue
        write_limit(9'd0);
        send_item(OP_OPEN, 4'd3, 16'h0, 1'b0, none);
        send_item(OP_ENQ, 4'd3, 16'hbeef, 1'b1, '{ST_FULL, 16'h0, 1'b0, 9'd0});
        wait_drained();

        // limit 256: fill the whole pool under a long output hold-off, then pool empty
        write_limit(9'd256);
        send_item(OP_OPEN, 4'd1, 16'h0, 1'b0, none);
        hold_req = 1;
        for (i = 0; i < 200; i++)
            send_item(OP_ENQ, 4'd3, 16'($urandom), 1'b0, none);
        for (i = 0; i < 56; i++)
            send_item(OP_ENQ, 4'd1, 16'($urandom), 1'b0, none);
        send_item(OP_ENQ, 4'd1, 16'h4242, 1'b1, '{ST_POOL, 16'h0, 1'b0, 9'd56});
        send_item(OP_DEQ, 4'd1, 16'h0, 1'b0, none);
        send_item(OP_CLOSE, 4'd3, 16'h0, 1'b0, none);
        send_item(OP_CLOSE, 4'd1, 16'h0, 1'b0, none);
        wait_drained();

        // random mix at a tight limit, then at a random one
        write_limit(9'd4);
        random_items(60);
        wait_drained();
        write_limit(9'($urandom_range(255, 1)));
        random_items(60);
        wait_drained();

        $display("%0d items sent, %0d results checked, %0d drops, %0d handles popped",
                 items_sent, results_seen, drops_seen, pops_seen);
        $display("limits 100, 0, 256, 4 and random; pool exhausted once under hold-off");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
rtl/pptdq_pkg.sv
rtl/per_port_tail_drop_queue_manager_top.sv
verif/per_port_tail_drop_queue_manager_top_tb.sv
